/* hw/rtl/tmtw_pkg.sv */
`default_nettype none

package tmtw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths of the command and result words.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CELL_W-1:0] SCROLL_CELL  = 16'h0020;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0]        COLOR_RESET  = 8'd7;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;   // capture the incoming word, restart the sweep counter
    logic exec;    // execute the captured word
    logic fill;    // write a blank cell at the sweep address
    logic scroll;  // one step of the scroll copy
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic scroll_needed;
    logic sweep_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/tmtw_ctrl.sv */
`default_nettype none

module tmtw_ctrl import tmtw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_ctl_t       ctl,
  output logic          busy,
  output logic          done
);

  state_t state, state_next;

  // State register; reset begins the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_INIT: begin
        ctl.fill = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_DONE: begin
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        unique case (stat.cmd)
          CMD_PUT:   state_next = stat.scroll_needed ? ST_SCROLL : ST_DONE;
          CMD_CLEAR: state_next = ST_CLEAR;
          CMD_READ:  state_next = ST_DONE;
          CMD_NOP:   state_next = ST_DONE;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_SCROLL: begin
        ctl.scroll = 1'b1;
        if (stat.sweep_last) state_next = ST_DONE;
      end
      ST_CLEAR: begin
        ctl.fill = 1'b1;
        if (stat.sweep_last) state_next = ST_DONE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/tmtw_datapath.sv */
`default_nettype none

module tmtw_datapath import tmtw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_ctl_t           ctl,
  output dp_stat_t               stat,
  input  wire logic              color_we,
  input  wire logic [7:0]        color_in,
  input  wire logic [1:0]        command,
  input  wire logic [CHAR_W-1:0] character,
  input  wire logic [ROW_W-1:0]  cell_row,
  input  wire logic [COL_W-1:0]  cell_column,
  output logic [CELL_W-1:0]      cell_value,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [COL_W-1:0]       cursor_column
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_q;

  cmd_t              cmd_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [7:0]        color;

  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] cnt;
  logic              pend;
  logic              pend_copy;
  logic [ADDR_W-1:0] pend_addr;
  logic              rd_ok;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [ADDR_W-1:0] copy_src;
  logic [CELL_W-1:0] pend_data;
  logic              is_nl;
  logic              at_eol;
  logic              at_last;
  logic              read_in_range;
  logic              copy_phase;

  // Address arithmetic and cursor conditions.
  always_comb begin
    cur_addr      = row_base + ADDR_W'(cur_col);
    read_addr     = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
    copy_src      = ADDR_W'(int'(cnt) + COLUMNS);
    copy_phase    = cnt < ADDR_W'(CELLS - COLUMNS);
    is_nl         = char_q == NEWLINE_CHAR;
    at_eol        = cur_col == COL_W'(COLUMNS - 1);
    at_last       = cur_row == ROW_W'(ROWS - 1);
    read_in_range = (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLUMNS));
    pend_data     = pend_copy ? mem_q : SCROLL_CELL;
  end

  assign stat.cmd           = cmd_q;
  assign stat.scroll_needed = (cmd_q == CMD_PUT) && (is_nl || at_eol) && at_last;
  assign stat.sweep_last    = cnt == ADDR_W'(CELLS - 1);

  // Captured command word.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q  <= cmd_t'(command);
      char_q <= character;
      row_q  <= cell_row;
      col_q  <= cell_column;
    end
  end

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_RESET;
    end else if (color_we) begin
      color <= color_in;
    end
  end

  // Sweep counter for clear and scroll, with the delayed scroll write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= ctl.scroll;
      if (ctl.latch) begin
        cnt <= '0;
      end else if (ctl.fill || ctl.scroll) begin
        cnt <= cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    pend_copy <= copy_phase;
  end

  // Cursor update.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      row_base <= '0;
    end else if (ctl.exec) begin
      if (cmd_q == CMD_PUT) begin
        if (is_nl || at_eol) begin
          cur_col <= '0;
          if (!at_last) begin
            cur_row  <= cur_row + ROW_W'(1);
            row_base <= ADDR_W'(int'(row_base) + COLUMNS);
          end
        end else begin
          cur_col <= cur_col + COL_W'(1);
        end
      end else if (cmd_q == CMD_CLEAR) begin
        cur_row  <= '0;
        cur_col  <= '0;
        row_base <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) rd_ok <= read_in_range;
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      mem[cnt] <= BLANK_CELL;
    end else if (pend) begin
      mem[pend_addr] <= pend_data;
    end else if (ctl.exec && (cmd_q == CMD_PUT) && !is_nl) begin
      mem[cur_addr] <= {color, char_q};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && (cmd_q == CMD_READ) && read_in_range) begin
      mem_q <= mem[read_addr];
    end else if (ctl.scroll && copy_phase) begin
      mem_q <= mem[copy_src];
    end
  end

  // Result word.
  assign cell_value    = ((cmd_q == CMD_READ) && rd_ok) ? mem_q : '0;
  assign cursor_row    = cur_row;
  assign cursor_column = cur_col;

endmodule

`default_nettype wire

/* hw/rtl/text_mode_terminal_writer.sv */
// Flow: a word accepted in the idle or done state goes through the execute
// state, then the done state, where its result is shown; a scroll or a clear
// sweeps the store before done, one screen cell per cycle on the store's port.
// A new word is taken in the done cycle, not while the block is busy.
// Reset: synchronous; a clearing pass of every cell follows, with busy high.
// Results are shown for one cycle under done; the receiver cannot stall.
`default_nettype none

module text_mode_terminal_writer import tmtw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        command,
  input  wire logic [CHAR_W-1:0] character,
  input  wire logic [ROW_W-1:0]  cell_row,
  input  wire logic [COL_W-1:0]  cell_column,
  output logic                   done,
  output logic [CELL_W-1:0]      cell_value,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [COL_W-1:0]       cursor_column,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        text_color
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // The attribute register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  tmtw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  tmtw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .color_we      (cfg_valid && cfg_ready),
    .color_in      (text_color),
    .command       (command),
    .character     (character),
    .cell_row      (cell_row),
    .cell_column   (cell_column),
    .cell_value    (cell_value),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column)
  );

endmodule

`default_nettype wire

/* hw/rtl/tmtw_checker.sv */
`default_nettype none

module tmtw_checker import tmtw_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic [ROW_W-1:0] cursor_row,
  input wire logic [COL_W-1:0] cursor_column
);

  // A result cycle also takes the next word.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy during a result cycle");

  // An accepted word occupies the block for its execute cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("word accepted without an execute cycle");

  // A result cycle is never followed directly by another.
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result shown twice");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((cursor_row < ROW_W'(ROWS)) && (cursor_column < COL_W'(COLUMNS))))
    else $error("cursor off the screen");

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .cursor_row    (cursor_row),
  .cursor_column (cursor_column)
);

`default_nettype wire
